[hdl/fmtp_pkg.sv]
// Shared types, constants and the square-root step for the FFT peak unit.
package fmtp_pkg;

	localparam int IDX_W    = 9;
	localparam int MAG_W    = 17;
	localparam int WORD_W   = 32;
	localparam int HALF_W   = 16;
	localparam int SUM_W    = 32;
	localparam int RAD_W    = 34;
	localparam int REM_W    = 20;
	localparam int SQ_STEPS = 17;
	localparam int IDX_MAX  = 511;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = 2;
	localparam int QCNT_W   = 3;
	localparam int NPEAKS   = 3;

	typedef struct packed {
		logic [SUM_W-1:0] sumsq;
		logic [IDX_W-1:0] idx;
		logic             last;
	} mq_item_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [MAG_W-1:0] root;
		logic [RAD_W-1:0] rad;
	} sq_state_t;

	typedef struct packed {
		logic [IDX_W-1:0]                   bin_index;
		logic [MAG_W-1:0]                   magnitude;
		logic                               frame_done;
		logic [NPEAKS-1:0][IDX_W-1:0]       pk_idx;
		logic [NPEAKS-1:0][MAG_W-1:0]       pk_mag;
	} out_item_t;

	// one radix-4 digit of the restoring square root
	function automatic sq_state_t sq_step(sq_state_t s);
		sq_state_t        r;
		logic [REM_W-1:0] rem_sh;
		logic [REM_W-1:0] trial;
		rem_sh = {s.rem[REM_W-3:0], s.rad[RAD_W-1:RAD_W-2]};
		trial  = {1'b0, s.root, 2'b01};
		r.rad  = {s.rad[RAD_W-3:0], 2'b00};
		if (rem_sh >= trial) begin
			r.rem  = rem_sh - trial;
			r.root = {s.root[MAG_W-2:0], 1'b1};
		end else begin
			r.rem  = rem_sh;
			r.root = {s.root[MAG_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

[hdl/fmtp_front.sv]
// Front end: accepts bins, numbers them and forms the sum of squares.
module fmtp_front #(
	parameter int BINS = 512
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [fmtp_pkg::WORD_W-1:0]       fft_word,
	input  logic                              last_bin,
	input  logic                              q_full,
	output logic                              q_push,
	output fmtp_pkg::mq_item_t                q_item
);

	localparam int LIMIT_I = (BINS - 1 < fmtp_pkg::IDX_MAX) ? BINS - 1 : fmtp_pkg::IDX_MAX;
	localparam logic [fmtp_pkg::IDX_W-1:0] LIMIT = fmtp_pkg::IDX_W'(LIMIT_I);

	logic [fmtp_pkg::IDX_W-1:0]  bin_cnt_q;
	logic                        v_s1;
	logic [fmtp_pkg::WORD_W-1:0] word_s1;
	logic                        last_s1;
	logic [fmtp_pkg::IDX_W-1:0]  idx_s1;
	logic                        accept;
	logic signed [fmtp_pkg::HALF_W-1:0] lo;
	logic signed [fmtp_pkg::HALF_W-1:0] hi;
	logic signed [2*fmtp_pkg::HALF_W-1:0] plo;
	logic signed [2*fmtp_pkg::HALF_W-1:0] phi;

	assign full   = v_s1 & q_full;
	assign accept = push & ~full;
	assign q_push = v_s1 & ~q_full;

	assign lo  = signed'(word_s1[fmtp_pkg::HALF_W-1:0]);
	assign hi  = signed'(word_s1[fmtp_pkg::WORD_W-1:fmtp_pkg::HALF_W]);
	assign plo = lo * lo;
	assign phi = hi * hi;

	always_comb begin
		q_item.sumsq = unsigned'(plo) + unsigned'(phi);
		q_item.idx   = idx_s1;
		q_item.last  = last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			bin_cnt_q <= fmtp_pkg::IDX_W'(1);
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
				if (last_bin) begin
					bin_cnt_q <= fmtp_pkg::IDX_W'(1);
				end else if (bin_cnt_q < LIMIT) begin
					bin_cnt_q <= bin_cnt_q + fmtp_pkg::IDX_W'(1);
				end
			end else if (q_push) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= fft_word;
			last_s1 <= last_bin;
			idx_s1  <= bin_cnt_q;
		end
	end

endmodule

[hdl/fmtp_queue.sv]
// Short item queue between the front end and the magnitude back end.
module fmtp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr,
	input  fmtp_pkg::mq_item_t wr_item,
	output logic               q_full,
	input  logic               rd,
	output logic               q_empty,
	output fmtp_pkg::mq_item_t rd_item
);

	fmtp_pkg::mq_item_t              buf_q [fmtp_pkg::QDEPTH];
	logic [fmtp_pkg::QPTR_W-1:0]     wp_q;
	logic [fmtp_pkg::QPTR_W-1:0]     rp_q;
	logic [fmtp_pkg::QCNT_W-1:0]     cnt_q;
	logic                            do_wr;
	logic                            do_rd;

	assign q_full  = (cnt_q == fmtp_pkg::QCNT_W'(fmtp_pkg::QDEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr & ~q_full;
	assign do_rd   = rd & ~q_empty;
	assign rd_item = buf_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= wp_q + fmtp_pkg::QPTR_W'(1);
			if (do_rd) rp_q <= rp_q + fmtp_pkg::QPTR_W'(1);
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + fmtp_pkg::QCNT_W'(1);
			end else if (!do_wr && do_rd) begin
				cnt_q <= cnt_q - fmtp_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) buf_q[wp_q] <= wr_item;
	end

endmodule

[hdl/fmtp_back.sv]
// Back end: pipelined square root, top-three tracker and result buffer.
module fmtp_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_empty,
	input  fmtp_pkg::mq_item_t      q_item,
	output logic                    q_pop,
	input  logic                    pop,
	output logic                    empty,
	output fmtp_pkg::out_item_t     res
);

	localparam int N = fmtp_pkg::SQ_STEPS;

	logic                              v_s   [N];
	fmtp_pkg::sq_state_t               st_s  [N];
	logic [fmtp_pkg::IDX_W-1:0]        idx_s [N];
	logic                              last_s[N];
	fmtp_pkg::sq_state_t               st_in;
	fmtp_pkg::sq_state_t               st_nx [N];

	logic [fmtp_pkg::NPEAKS-1:0][fmtp_pkg::MAG_W-1:0] pmag_q;
	logic [fmtp_pkg::NPEAKS-1:0][fmtp_pkg::IDX_W-1:0] pidx_q;
	logic [fmtp_pkg::NPEAKS-1:0][fmtp_pkg::MAG_W-1:0] nmag;
	logic [fmtp_pkg::NPEAKS-1:0][fmtp_pkg::IDX_W-1:0] nidx;
	logic [fmtp_pkg::MAG_W-1:0]        mag;
	logic [fmtp_pkg::IDX_W-1:0]        idx;
	logic                              last;

	fmtp_pkg::out_item_t               obuf_q [2];
	fmtp_pkg::out_item_t               oitem;
	logic                              owp_q;
	logic                              orp_q;
	logic [1:0]                        ocnt_q;
	logic                              opop;
	logic                              adv;
	logic                              ow;

	assign empty = (ocnt_q == 2'd0);
	assign opop  = pop & ~empty;
	assign adv   = (ocnt_q != 2'd2) | opop;
	assign q_pop = adv & ~q_empty;
	assign ow    = adv & v_s[N-1];
	assign res   = obuf_q[orp_q];

	always_comb begin
		st_in.rem  = '0;
		st_in.root = '0;
		st_in.rad  = {q_item.sumsq, 2'b00};
		st_nx[0]   = fmtp_pkg::sq_step(st_in);
		for (int k = 1; k < N; k++) begin
			st_nx[k] = fmtp_pkg::sq_step(st_s[k-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) v_s[k] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= q_pop;
			for (int k = 1; k < N; k++) v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s[0]   <= st_nx[0];
			idx_s[0]  <= q_item.idx;
			last_s[0] <= q_item.last;
			for (int k = 1; k < N; k++) begin
				st_s[k]   <= st_nx[k];
				idx_s[k]  <= idx_s[k-1];
				last_s[k] <= last_s[k-1];
			end
		end
	end

	assign mag  = st_s[N-1].root;
	assign idx  = idx_s[N-1];
	assign last = last_s[N-1];

	// insert with shift-down, strict greater-than
	always_comb begin
		nmag = pmag_q;
		nidx = pidx_q;
		if (mag > pmag_q[0]) begin
			nmag = {pmag_q[1], pmag_q[0], mag};
			nidx = {pidx_q[1], pidx_q[0], idx};
		end else if (mag > pmag_q[1]) begin
			nmag = {pmag_q[1], mag, pmag_q[0]};
			nidx = {pidx_q[1], idx, pidx_q[0]};
		end else if (mag > pmag_q[2]) begin
			nmag[2] = mag;
			nidx[2] = idx;
		end
	end

	always_comb begin
		oitem.bin_index  = idx;
		oitem.magnitude  = mag;
		oitem.frame_done = last;
		oitem.pk_idx     = last ? nidx : '0;
		oitem.pk_mag     = last ? nmag : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pmag_q <= '0;
			pidx_q <= '0;
			owp_q  <= 1'b0;
			orp_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (ow) begin
				pmag_q <= last ? '0 : nmag;
				pidx_q <= last ? '0 : nidx;
				owp_q  <= ~owp_q;
			end
			if (opop) orp_q <= ~orp_q;
			if (ow && !opop) begin
				ocnt_q <= ocnt_q + 2'd1;
			end else if (!ow && opop) begin
				ocnt_q <= ocnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ow) obuf_q[owp_q] <= oitem;
	end

endmodule

[hdl/fft_magnitude_top3_peaks_unit.sv]
// Top level of the FFT bin magnitude and top-three peak search unit.
//
// Each pushed item is one packed FFT bin (bits 15:0 and 31:16 signed halves);
// every item yields one result with its bin index, the magnitude
// floor(sqrt(4*(lo^2+hi^2))) and, on the item flagged last_bin, the three
// largest magnitudes of the frame with their bin indices (zero otherwise,
// and zero index for slots never filled). Ties keep the earlier bin. One
// item per clock is sustained while results are popped as they arrive; each
// item passes from the input register into the 4-entry queue between front
// and back end, then through 17 square-root stages into the 2-entry result
// buffer. Bin numbering restarts at 1 after a last bin and saturates at the
// smaller of BINS-1 and 511.
module fft_magnitude_top3_peaks_unit #(
	parameter int BINS = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] fft_word,
	input  logic        last_bin,
	output logic        empty,
	input  logic        pop,
	output logic [8:0]  bin_index,
	output logic [16:0] magnitude,
	output logic        frame_done,
	output logic [8:0]  first_index,
	output logic [8:0]  second_index,
	output logic [8:0]  third_index,
	output logic [16:0] first_mag,
	output logic [16:0] second_mag,
	output logic [16:0] third_mag
);

	fmtp_pkg::mq_item_t  f_item;
	fmtp_pkg::mq_item_t  b_item;
	fmtp_pkg::out_item_t res;
	logic                f_push;
	logic                q_full;
	logic                q_empty;
	logic                q_pop;

	fmtp_front #(
		.BINS(BINS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.fft_word(fft_word),
		.last_bin(last_bin),
		.q_full  (q_full),
		.q_push  (f_push),
		.q_item  (f_item)
	);

	fmtp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (f_push),
		.wr_item(f_item),
		.q_full (q_full),
		.rd     (q_pop),
		.q_empty(q_empty),
		.rd_item(b_item)
	);

	fmtp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_item (b_item),
		.q_pop  (q_pop),
		.pop    (pop),
		.empty  (empty),
		.res    (res)
	);

	assign bin_index    = res.bin_index;
	assign magnitude    = res.magnitude;
	assign frame_done   = res.frame_done;
	assign first_index  = res.pk_idx[0];
	assign second_index = res.pk_idx[1];
	assign third_index  = res.pk_idx[2];
	assign first_mag    = res.pk_mag[0];
	assign second_mag   = res.pk_mag[1];
	assign third_mag    = res.pk_mag[2];

endmodule
